// File: sv/trend_boosted_fan_band_control_unit_defines.svh
// Assertion macros for the trend-boosted fan band control unit.
// Included by the top level; expects clk and arst_n in scope.
`ifndef TREND_BOOSTED_FAN_BAND_CONTROL_UNIT_DEFINES_SVH
`define TREND_BOOSTED_FAN_BAND_CONTROL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted
`define TBFB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define TBFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TBFB_ASSERT_IMPL(lbl, ante, cons, msg)
`define TBFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/tbfb_pkg.sv
// Package for the trend-boosted fan band control unit.
// Field widths, register map, band codes and reset values; no dependencies.
package tbfb_pkg;

	// Payload and register widths
	localparam int TEMP_W  = 11;
	localparam int LIM_W   = 11;
	localparam int MASK_W  = 5;
	localparam int BOOST_W = 8;
	localparam int BAND_W  = 2;
	localparam int ADJ_W   = 12;

	// APB port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_BAND_TOP   = 3'd0,
		REG_HOT_FLOOR  = 3'd1,
		REG_WARM_FLOOR = 3'd2,
		REG_COOL_FLOOR = 3'd3,
		REG_HOT_MASK   = 3'd4,
		REG_WARM_MASK  = 3'd5,
		REG_COOL_MASK  = 3'd6,
		REG_RISE_BOOST = 3'd7
	} cfg_reg_t;

	// Band codes as reported on band_hit
	typedef enum logic [BAND_W-1:0] {
		BAND_NONE = 2'd0,
		BAND_COOL = 2'd1,
		BAND_WARM = 2'd2,
		BAND_HOT  = 2'd3
	} band_t;

	// Register reset values
	localparam logic [LIM_W-1:0]   BAND_TOP_RST   = 11'd1100;
	localparam logic [LIM_W-1:0]   HOT_FLOOR_RST  = 11'd730;
	localparam logic [LIM_W-1:0]   WARM_FLOOR_RST = 11'd600;
	localparam logic [LIM_W-1:0]   COOL_FLOOR_RST = 11'd300;
	localparam logic [MASK_W-1:0]  HOT_MASK_RST   = 5'd25;
	localparam logic [MASK_W-1:0]  WARM_MASK_RST  = 5'd27;
	localparam logic [MASK_W-1:0]  COOL_MASK_RST  = 5'd31;
	localparam logic [BOOST_W-1:0] RISE_BOOST_RST = 8'd50;

endpackage

// File: sv/tbfb_if.sv
// Valid/ready channel interfaces for samples in and fan results out.
// Depends on tbfb_pkg for field widths.
interface tbfb_sample_if;
	import tbfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [TEMP_W-1:0] temp_sample;

	modport source (output valid, output temp_sample, input ready);
	modport sink (input valid, input temp_sample, output ready);
endinterface

interface tbfb_result_if;
	import tbfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] fan_mask;
	logic [BAND_W-1:0] band_hit;
	logic              boosted;

	modport source (output valid, output fan_mask, output band_hit, output boosted,
		input ready);
	modport sink (input valid, input fan_mask, input band_hit, input boosted,
		output ready);
endinterface

// File: sv/trend_boosted_fan_band_control_unit.sv
// Trend-boosted fan band control unit: top level.
// Depends on tbfb_pkg, the channel interfaces and the assertion macro header.

// One temperature sample (tenths of a degree) is taken per transaction, and one
// result comes out per sample, in order. A new sample can be accepted every
// clock cycle while results are taken; a result passes stage 1, stage 2 and the
// result register (ring/sum update, mean compare and boost, band select) and can
// be taken at the next edge. Up to three samples can be in flight, so input stays
// open while a finished result waits to be taken, until stages 1 and 2 are full.
// The last WINDOW samples sit in a single-port-write, single-port-read ring
// memory whose next-to-be-evicted entry is prefetched each cycle; that memory read
// is what sets the one-sample-per-cycle rate. Configuration goes
// through an APB port (registers at byte address 4*index) and must be written
// only while the unit is idle. A sample above the running mean gets rise_boost
// added; the adjusted value picks the cool, warm or hot band (cooler band wins
// on overlap) and the band's fan mask, otherwise the previous mask is kept.

`include "trend_boosted_fan_band_control_unit_defines.svh"

module trend_boosted_fan_band_control_unit #(
	parameter int WINDOW    = 20,
	parameter int FAN_COUNT = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbfb_pkg::APB_AW-1:0]   paddr,
	input  logic [tbfb_pkg::APB_DW-1:0]   pwdata,
	output logic [tbfb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	tbfb_sample_if.sink                   samples,
	tbfb_result_if.source                 results
);
	import tbfb_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW * ((1 << TEMP_W) - 1) + 1);
	localparam int PROD_W = TEMP_W + CNT_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);
	localparam logic [MASK_W-1:0] FAN_BITS  = MASK_W'(((1 << FAN_COUNT) - 1) & 31);

	// Configuration registers
	logic [LIM_W-1:0]   band_top_q, hot_floor_q, warm_floor_q, cool_floor_q;
	logic [MASK_W-1:0]  hot_mask_q, warm_mask_q, cool_mask_q;
	logic [BOOST_W-1:0] rise_boost_q;
	logic               cfg_wr;
	cfg_reg_t           cfg_idx;

	// Window state
	logic [TEMP_W-1:0] ring_mem [WINDOW];
	logic [TEMP_W-1:0] old_q;
	logic [SLOT_W-1:0] slot_q, slot_next, rd_addr;
	logic [CNT_W-1:0]  fill_q, fill_next;
	logic [SUM_W-1:0]  sum_q, sum_next;
	logic              full;

	// Pipeline
	logic              v_s1, v_s2, out_v_q;
	logic [TEMP_W-1:0] sample_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic [CNT_W-1:0]  fill_s1;
	logic [ADJ_W-1:0]  temp_s2;
	logic              boosted_s2;
	band_t             band_q;
	logic              boosted_q;
	logic [MASK_W-1:0] held_mask_q;

	logic              out_rdy, adv1, adv2, take_in, move2;
	logic [PROD_W-1:0] prod;
	logic              above_mean;
	logic [ADJ_W-1:0]  temp_adj;
	band_t             band_next;
	logic [MASK_W-1:0] mask_next;

	// APB access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[4:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_BAND_TOP:   prdata = APB_DW'(band_top_q);
			REG_HOT_FLOOR:  prdata = APB_DW'(hot_floor_q);
			REG_WARM_FLOOR: prdata = APB_DW'(warm_floor_q);
			REG_COOL_FLOOR: prdata = APB_DW'(cool_floor_q);
			REG_HOT_MASK:   prdata = APB_DW'(hot_mask_q);
			REG_WARM_MASK:  prdata = APB_DW'(warm_mask_q);
			REG_COOL_MASK:  prdata = APB_DW'(cool_mask_q);
			REG_RISE_BOOST: prdata = APB_DW'(rise_boost_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_top_q   <= BAND_TOP_RST;
			hot_floor_q  <= HOT_FLOOR_RST;
			warm_floor_q <= WARM_FLOOR_RST;
			cool_floor_q <= COOL_FLOOR_RST;
			hot_mask_q   <= HOT_MASK_RST;
			warm_mask_q  <= WARM_MASK_RST;
			cool_mask_q  <= COOL_MASK_RST;
			rise_boost_q <= RISE_BOOST_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BAND_TOP:   band_top_q   <= pwdata[LIM_W-1:0];
				REG_HOT_FLOOR:  hot_floor_q  <= pwdata[LIM_W-1:0];
				REG_WARM_FLOOR: warm_floor_q <= pwdata[LIM_W-1:0];
				REG_COOL_FLOOR: cool_floor_q <= pwdata[LIM_W-1:0];
				REG_HOT_MASK:   hot_mask_q   <= pwdata[MASK_W-1:0];
				REG_WARM_MASK:  warm_mask_q  <= pwdata[MASK_W-1:0];
				REG_COOL_MASK:  cool_mask_q  <= pwdata[MASK_W-1:0];
				REG_RISE_BOOST: rise_boost_q <= pwdata[BOOST_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: each stage loads when it is empty or its content moves on
	assign out_rdy       = !out_v_q || results.ready;
	assign adv2          = !v_s2 || out_rdy;
	assign adv1          = !v_s1 || adv2;
	assign samples.ready = adv1;
	assign take_in       = samples.valid && adv1;
	assign move2         = v_s2 && out_rdy;

	// Ring bookkeeping: evict the oldest sample once the window is full
	assign full      = (fill_q == FULL_CNT);
	assign slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign fill_next = full ? fill_q : fill_q + 1'b1;
	assign sum_next  = sum_q - (full ? SUM_W'(old_q) : '0) + SUM_W'(samples.temp_sample);
	// Prefetch the entry that the next transaction will overwrite
	assign rd_addr   = take_in ? slot_next : slot_q;

	always_ff @(posedge clk) begin
		if (take_in) begin
			ring_mem[slot_q] <= samples.temp_sample;
		end
		old_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (take_in) begin
			slot_q <= slot_next;
			fill_q <= fill_next;
			sum_q  <= sum_next;
		end
	end

	// Stage 1: sample with the sum and count that include it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= samples.temp_sample;
			sum_s1    <= sum_next;
			fill_s1   <= fill_next;
		end
	end

	// Mean compare without division: sample * count > sum
	assign prod       = PROD_W'(sample_s1) * PROD_W'(fill_s1);
	assign above_mean = prod > PROD_W'(sum_s1);
	assign temp_adj   = ADJ_W'(sample_s1) + (above_mean ? ADJ_W'(rise_boost_q) : '0);

	// Stage 2: adjusted temperature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			temp_s2    <= temp_adj;
			boosted_s2 <= above_mean;
		end
	end

	// Band select, cooler band first
	always_comb begin
		band_next = BAND_NONE;
		mask_next = held_mask_q;
		priority if (temp_s2 >= ADJ_W'(cool_floor_q) && temp_s2 <= ADJ_W'(warm_floor_q)) begin
			band_next = BAND_COOL;
			mask_next = cool_mask_q & FAN_BITS;
		end else if (temp_s2 >= ADJ_W'(warm_floor_q) && temp_s2 <= ADJ_W'(hot_floor_q)) begin
			band_next = BAND_WARM;
			mask_next = warm_mask_q & FAN_BITS;
		end else if (temp_s2 >= ADJ_W'(hot_floor_q) && temp_s2 <= ADJ_W'(band_top_q)) begin
			band_next = BAND_HOT;
			mask_next = hot_mask_q & FAN_BITS;
		end else begin
			band_next = BAND_NONE;
			mask_next = held_mask_q;
		end
	end

	// Result register; the held mask doubles as the fan_mask output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			held_mask_q <= '0;
		end else begin
			if (out_rdy) begin
				out_v_q <= v_s2;
			end
			if (move2) begin
				held_mask_q <= mask_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			band_q    <= band_next;
			boosted_q <= boosted_s2;
		end
	end

	assign results.valid    = out_v_q;
	assign results.fan_mask = held_mask_q;
	assign results.band_hit = band_q;
	assign results.boosted  = boosted_q;

	// Checks
	`TBFB_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FULL_CNT, "fill count above window")
	`TBFB_ASSERT_IMPL(a_slot_bound, 1'b1, slot_q <= LAST_SLOT, "write slot outside ring")
	`TBFB_ASSERT_NEXT(a_hold_mask, move2 && band_next == BAND_NONE, held_mask_q == $past(held_mask_q), "mask changed with no band hit")
	`TBFB_ASSERT_IMPL(a_fan_bits, out_v_q, (held_mask_q & ~FAN_BITS) == '0, "fan bit set beyond fan count")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the trend-boosted fan band control unit.
// Drives samples and APB register writes, predicts every fan result, checks them in order.
// Depends on tbfb_pkg, the channel interfaces in tbfb_if.sv and the top-level RTL.
module tb;
	import tbfb_pkg::*;

	localparam int WINDOW      = 20;
	localparam int FAN_COUNT   = 5;
	localparam logic [MASK_W-1:0] FAN_BITS = MASK_W'(((1 << FAN_COUNT) - 1) & 31);
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 6;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		logic [MASK_W-1:0] fan_mask;
		band_t             band;
		logic              boosted;
	} fan_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	tbfb_sample_if samp ();
	tbfb_result_if res ();

	trend_boosted_fan_band_control_unit #(
		.WINDOW    (WINDOW),
		.FAN_COUNT (FAN_COUNT)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samp),
		.results (res)
	);

	// Shadow copy of the block: configuration
	logic [LIM_W-1:0]   lim_top, lim_hot, lim_warm, lim_cool;
	logic [MASK_W-1:0]  mask_hot, mask_warm, mask_cool;
	logic [BOOST_W-1:0] boost_amt;

	// Shadow copy of the block: temperature history and held mask
	logic [TEMP_W-1:0]  hist_ring [WINDOW];
	int unsigned        hist_sum, hist_fill, hist_slot;
	logic [MASK_W-1:0]  held_mask;

	fan_result_t pending_fan [$];
	int errors;
	int results_checked;
	int settings_used;
	int drift_temp;
	bit calm;

	// Clock: 20 time units
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$error("run timed out with %0d results pending", pending_fan.size());
		$display("FAIL");
		$finish;
	end

	// Next fan result for one accepted sample; advances the shadow state
	function automatic fan_result_t predict_fan(input logic [TEMP_W-1:0] t);
		fan_result_t r;
		int unsigned idx;
		logic [ADJ_W-1:0] adj;
		idx = hist_slot;
		if (hist_fill >= WINDOW)
			hist_sum -= hist_ring[idx];
		else
			hist_fill++;
		hist_ring[idx] = t;
		hist_sum += t;
		hist_slot = (idx + 1) % WINDOW;

		// above the mean: t * count > sum, no divide
		adj = ADJ_W'(t);
		r.boosted = 1'b0;
		if (t * hist_fill > hist_sum) begin
			adj = ADJ_W'(t) + ADJ_W'(boost_amt);
			r.boosted = 1'b1;
		end

		// cooler band wins on shared edges and overlap
		r.band = BAND_NONE;
		if (adj >= lim_cool && adj <= lim_warm) begin
			r.band = BAND_COOL;
			held_mask = mask_cool;
		end else if (adj >= lim_warm && adj <= lim_hot) begin
			r.band = BAND_WARM;
			held_mask = mask_warm;
		end else if (adj >= lim_hot && adj <= lim_top) begin
			r.band = BAND_HOT;
			held_mask = mask_hot;
		end
		held_mask &= FAN_BITS;
		r.fan_mask = held_mask;
		return r;
	endfunction

	// Result sink: random back-pressure unless calm
	always @(negedge clk) begin
		res.ready <= calm || ($urandom_range(0, 99) >= 20);
	end

	// Result checker
	always @(posedge clk) begin : check_results
		fan_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_fan.size() == 0) begin
				$error("result transaction with no sample pending");
				errors++;
			end else begin
				want = pending_fan.pop_front();
				results_checked++;
				if (res.fan_mask !== want.fan_mask) begin
					$error("fan_mask expected %0d actual %0d", want.fan_mask, res.fan_mask);
					errors++;
				end
				if (res.band_hit !== want.band) begin
					$error("band_hit expected %0d actual %0d", want.band, res.band_hit);
					errors++;
				end
				if (res.boosted !== want.boosted) begin
					$error("boosted expected %0d actual %0d", want.boosted, res.boosted);
					errors++;
				end
			end
		end
	end

	// One sample transaction; entered and left at a falling edge
	task automatic send_sample(input logic [TEMP_W-1:0] t);
		while (!calm && $urandom_range(0, 99) < 20) begin
			samp.valid <= 1'b0;
			samp.temp_sample <= TEMP_W'($urandom);
			@(negedge clk);
		end
		samp.valid <= 1'b1;
		samp.temp_sample <= t;
		@(posedge clk);
		while (!samp.ready) @(posedge clk);
		pending_fan.push_back(predict_fan(t));
		@(negedge clk);
	endtask

	// Stop sending, let all results drain and the pipeline settle
	task automatic wait_idle();
		samp.valid <= 1'b0;
		while (pending_fan.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// APB write then read-back of one register
	task automatic cfg_write(input cfg_reg_t r, input logic [APB_DW-1:0] v);
		logic [APB_DW-1:0] keep;
		logic [APB_DW-1:0] want;
		case (r)
			REG_BAND_TOP, REG_HOT_FLOOR, REG_WARM_FLOOR, REG_COOL_FLOOR: keep = 32'h7FF;
			REG_HOT_MASK, REG_WARM_MASK, REG_COOL_MASK:                  keep = 32'h1F;
			default:                                                     keep = 32'hFF;
		endcase
		want = v & keep;
		case (r)
			REG_BAND_TOP:   lim_top   = want[LIM_W-1:0];
			REG_HOT_FLOOR:  lim_hot   = want[LIM_W-1:0];
			REG_WARM_FLOOR: lim_warm  = want[LIM_W-1:0];
			REG_COOL_FLOOR: lim_cool  = want[LIM_W-1:0];
			REG_HOT_MASK:   mask_hot  = want[MASK_W-1:0];
			REG_WARM_MASK:  mask_warm = want[MASK_W-1:0];
			REG_COOL_MASK:  mask_cool = want[MASK_W-1:0];
			default:        boost_amt = want[BOOST_W-1:0];
		endcase

		// setup, access; unused upper data bits carry noise
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= ($urandom & ~keep) | want;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);

		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata of %s expected %0d actual %0d", r.name(), want, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		// bus idle between transfers
		@(negedge clk);
	endtask

	// Full register set, written while idle
	task automatic cfg_all(input int top, input int hot, input int warm, input int cool,
		input int hm, input int wm, input int cm, input int boost);
		wait_idle();
		cfg_write(REG_BAND_TOP, top);
		cfg_write(REG_HOT_FLOOR, hot);
		cfg_write(REG_WARM_FLOOR, warm);
		cfg_write(REG_COOL_FLOOR, cool);
		cfg_write(REG_HOT_MASK, hm);
		cfg_write(REG_WARM_MASK, wm);
		cfg_write(REG_COOL_MASK, cm);
		cfg_write(REG_RISE_BOOST, boost);
		@(negedge clk);
		settings_used++;
	endtask

	// Reset values, field extremes and the band limits of the defaults
	task automatic test_reset_values();
		send_sample(11'd0);
		send_sample(11'd2047);
		send_sample(11'd1500);
		send_sample(11'd300);
		send_sample(11'd600);
		send_sample(11'd730);
		send_sample(11'd1100);
		send_sample(11'd1101);
		send_sample(11'd299);
		send_sample(11'd0);
	endtask

	// All registers at zero, then all at their maximum
	task automatic test_register_extremes();
		cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
		send_sample(11'd0);
		send_sample(11'd2047);
		send_sample(11'd1);
		cfg_all(2047, 2047, 2047, 2047, 31, 31, 31, 255);
		send_sample(11'd2047);
		send_sample(11'd1792);
		send_sample(11'd0);
	endtask

	// Shared edges, empty hot band, then misordered floors; ring wraps here
	task automatic test_band_priority();
		cfg_all(450, 500, 500, 400, 1, 2, 4, 0);
		send_sample(11'd400);
		send_sample(11'd500);
		send_sample(11'd450);
		send_sample(11'd399);
		send_sample(11'd501);
		cfg_all(1200, 1000, 200, 900, 8, 16, 3, 0);
		send_sample(11'd950);
		send_sample(11'd500);
		send_sample(11'd1100);
	endtask

	// Random register set: ordered, fully random, or with collapsed edges
	task automatic cfg_random();
		int lims [4];
		int kind, i, j, tmp, boost;
		kind = $urandom_range(0, 3);
		for (i = 0; i < 4; i++)
			lims[i] = (kind == 0) ? $urandom_range(0, 1500) : $urandom_range(0, 2047);
		if (kind != 1) begin
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3 - i; j++)
					if (lims[j] > lims[j + 1]) begin
						tmp = lims[j];
						lims[j] = lims[j + 1];
						lims[j + 1] = tmp;
					end
		end
		if (kind == 2) begin
			j = $urandom_range(0, 2);
			lims[j + 1] = lims[j];
		end
		boost = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
		cfg_all(lims[3], lims[2], lims[1], lims[0], $urandom_range(0, 31),
			$urandom_range(0, 31), $urandom_range(0, 31), boost);
	endtask

	// Mostly slow temperature drift, some samples hugging band edges, some noise
	task automatic test_random_traffic();
		int p, n, edge_at, t;
		for (p = 0; p < PHASES; p++) begin
			cfg_random();
			calm = (p == 3);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 9))
					0: t = $urandom_range(0, 2047);
					1, 2: begin
						case ($urandom_range(0, 3))
							0: edge_at = lim_cool;
							1: edge_at = lim_warm;
							2: edge_at = lim_hot;
							default: edge_at = lim_top;
						endcase
						if ($urandom_range(0, 1))
							edge_at -= boost_amt;
						t = edge_at + $urandom_range(0, 6) - 3;
					end
					default: t = drift_temp + $urandom_range(0, 80) - 40;
				endcase
				if (t < 0) t = 0;
				if (t > 2047) t = 2047;
				if (t <= 1500) drift_temp = t;
				send_sample(TEMP_W'(t));
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		// known inputs from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samp.valid = 1'b0;
		samp.temp_sample = '0;
		calm = 1'b0;
		errors = 0;
		results_checked = 0;
		settings_used = 1;
		drift_temp = 600;

		lim_top = BAND_TOP_RST;
		lim_hot = HOT_FLOOR_RST;
		lim_warm = WARM_FLOOR_RST;
		lim_cool = COOL_FLOOR_RST;
		mask_hot = HOT_MASK_RST;
		mask_warm = WARM_MASK_RST;
		mask_cool = COOL_MASK_RST;
		boost_amt = RISE_BOOST_RST;
		hist_sum = 0;
		hist_fill = 0;
		hist_slot = 0;
		held_mask = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_register_extremes();
		test_band_priority();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		if (pending_fan.size() != 0) begin
			$error("%0d expected results never arrived", pending_fan.size());
			errors++;
		end
		$display("Checked %0d fan results across %0d register settings, %0d mismatches.",
			results_checked, settings_used, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
